// ----- hdl/ihrc_pkg.sv -----
`default_nettype none

package ihrc_pkg;

    localparam int LABEL_BITS_DEF = 16;
    localparam int LABEL_BITS_MAX = 32;
    localparam int STEPS_W        = 8;
    localparam int COLOR_W        = 8;
    localparam int SECTOR_W       = 3;
    localparam int NUM_W          = 14;
    localparam int DEN_W          = STEPS_W + 3;
    localparam int PROD_W         = DEN_W + COLOR_W;

    localparam logic [STEPS_W-1:0] HUE_STEPS_RST = 8'd8;
    localparam logic [COLOR_W-1:0] LEVEL_MAX     = 8'hFF;
    localparam logic [COLOR_W-1:0] LEVEL_MIN     = 8'h00;

    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED_GREEN_UP   = 3'd0,
        SEC_GREEN_RED_DOWN = 3'd1,
        SEC_GREEN_BLUE_UP  = 3'd2,
        SEC_BLUE_GREEN_DN  = 3'd3,
        SEC_BLUE_RED_UP    = 3'd4,
        SEC_RED_BLUE_DOWN  = 3'd5
    } t_sector;

    // The hue offset, in eighths of a step, for each value of the quotient modulo 7.
    function automatic logic [2:0] off_eighths(input logic [2:0] q7);
        logic [2:0] off;
        case (q7)
            3'd0: off = 3'd4;
            3'd1: off = 3'd2;
            3'd2: off = 3'd6;
            3'd3: off = 3'd1;
            3'd4: off = 3'd3;
            3'd5: off = 3'd5;
            3'd6: off = 3'd7;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Since 64 and 8 are both congruent to 1 modulo 7, the value is folded by
    // summing six-bit and then three-bit digits.
    function automatic logic [2:0] mod7(input logic [LABEL_BITS_MAX-1:0] q);
        logic [35:0] x;
        logic [8:0]  s6;
        logic [4:0]  s3;
        logic [3:0]  f;
        logic [2:0]  g;
        x  = {4'b0, q};
        s6 = '0;
        for (int i = 0; i < 6; i++) begin
            s6 = s6 + 9'(x[6*i +: 6]);
        end
        s3 = 5'(s6[2:0]) + 5'(s6[5:3]) + 5'(s6[8:6]);
        f  = 4'(s3[2:0]) + 4'(s3[4:3]);
        g  = f[2:0] + 3'(f[3]);
        return (g == 3'd7) ? 3'd0 : g;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ihrc_div_cell.sv -----
`default_nettype none

module ihrc_div_cell #(
    parameter int W  = 8,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [W-1:0]  i_rem,
    input  wire logic [W-1:0]  i_div,
    input  wire logic [SW-1:0] i_sh,
    output logic               o_vld,
    output logic [W-1:0]       o_rem,
    output logic [W-1:0]       o_div,
    output logic [SW-1:0]      o_sh
);

    logic          r_vld;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [SW-1:0] r_sh;
    logic [W-1:0]  n_rem;
    logic [SW-1:0] n_sh;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    // One restoring step: bring down the next dividend bit and subtract the
    // divisor when it fits; the quotient bit enters at the bottom of the shift word.
    assign trial = {i_rem, i_sh[SW-1]};
    assign diff  = trial - {1'b0, i_div};
    assign ge    = (trial >= {1'b0, i_div});
    assign n_rem = ge ? diff[W-1:0] : trial[W-1:0];
    assign n_sh  = {i_sh[SW-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= i_div;
        r_sh  <= n_sh;
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_sh  = r_sh;

endmodule

`default_nettype wire

// ----- hdl/ihrc_chain.sv -----
`default_nettype none

module ihrc_chain #(
    parameter int N  = 8,
    parameter int W  = 8,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [W-1:0]  i_rem,
    input  wire logic [W-1:0]  i_div,
    input  wire logic [SW-1:0] i_sh,
    output logic               o_vld,
    output logic [W-1:0]       o_rem,
    output logic [W-1:0]       o_div,
    output logic [SW-1:0]      o_sh
);

    logic          vld [N+1];
    logic [W-1:0]  rem [N+1];
    logic [W-1:0]  dv  [N+1];
    logic [SW-1:0] sh  [N+1];

    assign vld[0] = i_vld;
    assign rem[0] = i_rem;
    assign dv[0]  = i_div;
    assign sh[0]  = i_sh;

    for (genvar k = 0; k < N; k++) begin : g_cell
        ihrc_div_cell #(
            .W  (W),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[k]),
            .i_rem   (rem[k]),
            .i_div   (dv[k]),
            .i_sh    (sh[k]),
            .o_vld   (vld[k+1]),
            .o_rem   (rem[k+1]),
            .o_div   (dv[k+1]),
            .o_sh    (sh[k+1])
        );
    end

    assign o_vld = vld[N];
    assign o_rem = rem[N];
    assign o_div = dv[N];
    assign o_sh  = sh[N];

endmodule

`default_nettype wire

// ----- hdl/index_to_hue_rgb_color.sv -----
`default_nettype none

// Maps a label number to a fully saturated RGB color on a six-sector hue wheel.
// One label is taken on every clock: busy is never asserted, and each color
// appears on o_red, o_green and o_blue for exactly one cycle with o_done high.
// The receiver cannot stall the block, so it must take every result in the
// cycle it is shown. The color is computed by three chains of restoring divide
// cells, one quotient bit per cell: LABEL_BITS cells split the label by the
// step count, three cells find the hue sector and eight cells find the ramp
// level, with the p1 and p2 registers before the sector chain and the p3
// register before the ramp chain. The hue_steps register (reset value 8, zero
// acts as one) is written through the configuration channel, which is always
// ready; it must be written only while no request is in flight.
module index_to_hue_rgb_color
    import ihrc_pkg::*;
#(
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [LABEL_BITS-1:0] i_label_number,
    output logic                       o_done,
    output logic [COLOR_W-1:0]         o_red,
    output logic [COLOR_W-1:0]         o_green,
    output logic [COLOR_W-1:0]         o_blue,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [STEPS_W-1:0]    i_cfg_data
);

    localparam int LATENCY = LABEL_BITS + 15;

    logic [STEPS_W-1:0]    r_hue_steps;
    logic [STEPS_W-1:0]    steps_eff;

    logic                  a_vld;
    logic                  a_vld_out;
    logic [STEPS_W-1:0]    a_rem;
    logic [STEPS_W-1:0]    a_div;
    logic [LABEL_BITS-1:0] a_sh;

    logic                  r_p1_vld;
    logic [2:0]            r_p1_q7;
    logic [STEPS_W-1:0]    r_p1_res;
    logic [STEPS_W-1:0]    r_p1_stp;
    logic [2:0]            n_p1_q7;

    logic                  r_p2_vld;
    logic [NUM_W-1:0]      r_p2_num;
    logic [DEN_W-1:0]      r_p2_den;
    logic [NUM_W-1:0]      n_p2_num;
    logic [2:0]            p1_off;

    logic                  b_vld;
    logic [DEN_W-1:0]      b_rem;
    logic [DEN_W-1:0]      b_div;
    logic [SECTOR_W-1:0]   b_sh;

    logic                  r_p3_vld;
    logic [PROD_W-1:0]     r_p3_prod;
    logic [DEN_W-1:0]      r_p3_den;
    logic [SECTOR_W-1:0]   r_p3_sec;
    logic [PROD_W-1:0]     n_p3_prod;

    logic                  c_vld;
    logic [DEN_W-1:0]      c_rem;
    logic [DEN_W-1:0]      c_div;
    logic [SECTOR_W+COLOR_W-1:0] c_sh;

    t_sector               sec;
    logic [COLOR_W-1:0]    up;
    logic [COLOR_W-1:0]    down;
    logic                  r_done;
    logic [COLOR_W-1:0]    r_red;
    logic [COLOR_W-1:0]    r_green;
    logic [COLOR_W-1:0]    r_blue;
    logic [COLOR_W-1:0]    n_red;
    logic [COLOR_W-1:0]    n_green;
    logic [COLOR_W-1:0]    n_blue;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_steps <= HUE_STEPS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hue_steps <= i_cfg_data;
        end
    end

    assign steps_eff = (r_hue_steps == '0) ? STEPS_W'(1) : r_hue_steps;
    assign a_vld     = start & ~busy;

    ihrc_chain #(
        .N  (LABEL_BITS),
        .W  (STEPS_W),
        .SW (LABEL_BITS)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .i_rem   ('0),
        .i_div   (steps_eff),
        .i_sh    (i_label_number),
        .o_vld   (a_vld_out),
        .o_rem   (a_rem),
        .o_div   (a_div),
        .o_sh    (a_sh)
    );

    assign n_p1_q7 = mod7(LABEL_BITS_MAX'(a_sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_p1_vld <= a_vld_out;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= b_vld;
            r_done   <= c_vld;
        end
    end

    assign p1_off   = off_eighths(r_p1_q7);
    assign n_p2_num = NUM_W'({r_p1_res, 5'b0}) + NUM_W'({r_p1_res, 4'b0})
                    + NUM_W'({p1_off, 2'b0}) + NUM_W'({p1_off, 1'b0});

    always_ff @(posedge i_clk) begin
        r_p1_q7  <= n_p1_q7;
        r_p1_res <= a_rem;
        r_p1_stp <= a_div;
        r_p2_num <= n_p2_num;
        r_p2_den <= {r_p1_stp, 3'b0};
    end

    ihrc_chain #(
        .N  (SECTOR_W),
        .W  (DEN_W),
        .SW (SECTOR_W)
    ) u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p2_vld),
        .i_rem   (r_p2_num[NUM_W-1:SECTOR_W]),
        .i_div   (r_p2_den),
        .i_sh    (r_p2_num[SECTOR_W-1:0]),
        .o_vld   (b_vld),
        .o_rem   (b_rem),
        .o_div   (b_div),
        .o_sh    (b_sh)
    );

    assign n_p3_prod = {b_rem, {COLOR_W{1'b0}}} - PROD_W'(b_rem);

    always_ff @(posedge i_clk) begin
        r_p3_prod <= n_p3_prod;
        r_p3_den  <= b_div;
        r_p3_sec  <= b_sh;
    end

    // The sector code rides below the dividend bits and ends up above the ramp quotient.
    ihrc_chain #(
        .N  (COLOR_W),
        .W  (DEN_W),
        .SW (SECTOR_W + COLOR_W)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p3_vld),
        .i_rem   (r_p3_prod[PROD_W-1:COLOR_W]),
        .i_div   (r_p3_den),
        .i_sh    ({r_p3_prod[COLOR_W-1:0], r_p3_sec}),
        .o_vld   (c_vld),
        .o_rem   (c_rem),
        .o_div   (c_div),
        .o_sh    (c_sh)
    );

    assign sec  = t_sector'(c_sh[SECTOR_W+COLOR_W-1:COLOR_W]);
    assign up   = c_sh[COLOR_W-1:0];
    assign down = LEVEL_MAX - up;

    always_comb begin
        case (sec)
            SEC_RED_GREEN_UP: begin
                n_red = LEVEL_MAX; n_green = up;        n_blue = LEVEL_MIN;
            end
            SEC_GREEN_RED_DOWN: begin
                n_red = down;      n_green = LEVEL_MAX; n_blue = LEVEL_MIN;
            end
            SEC_GREEN_BLUE_UP: begin
                n_red = LEVEL_MIN; n_green = LEVEL_MAX; n_blue = up;
            end
            SEC_BLUE_GREEN_DN: begin
                n_red = LEVEL_MIN; n_green = down;      n_blue = LEVEL_MAX;
            end
            SEC_BLUE_RED_UP: begin
                n_red = up;        n_green = LEVEL_MIN; n_blue = LEVEL_MAX;
            end
            default: begin
                n_red = LEVEL_MAX; n_green = LEVEL_MIN; n_blue = down;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_done  = r_done;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_done)
        else $error("request did not produce a color after the pipeline latency");

    a_resid_lt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> (r_p1_res < r_p1_stp))
        else $error("label residue not below the step count");

    a_full_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_red == LEVEL_MAX || o_green == LEVEL_MAX || o_blue == LEVEL_MAX))
        else $error("color has no channel at full level");

    a_zero_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_red == LEVEL_MIN || o_green == LEVEL_MIN || o_blue == LEVEL_MIN))
        else $error("color has no channel at zero level");

    a_ramp_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_vld |-> (c_rem < c_div))
        else $error("ramp remainder not below the denominator");

endmodule

`default_nettype wire

// ----- sim/index_to_hue_rgb_color_test.sv -----
`timescale 1ns / 1ps

module index_to_hue_rgb_color_test;
    import ihrc_pkg::*;

    typedef enum logic [1:0] {
        REQ_LABEL,
        REQ_SET_STEPS,
        REQ_DRAIN,
        REQ_IDLE_RATE
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        int unsigned value;
    } t_plan_entry;

    typedef struct {
        logic [LABEL_BITS_DEF-1:0] label;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } t_color;

    localparam int LATENCY = LABEL_BITS_DEF + 15;
    localparam int unsigned OFFSET_EIGHTHS [7] = '{4, 2, 6, 1, 3, 5, 7};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [LABEL_BITS_DEF-1:0] i_label_number = '0;
    logic                      o_done;
    logic [COLOR_W-1:0]        o_red;
    logic [COLOR_W-1:0]        o_green;
    logic [COLOR_W-1:0]        o_blue;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [STEPS_W-1:0]        i_cfg_data = '0;

    t_plan_entry        request_plan [$];
    t_color             colors_due [$];
    logic [STEPS_W-1:0] steps_now = 8'd8;
    logic               running = 1'b0;
    logic               req_taken = 1'b0;
    logic               cfg_taken = 1'b0;
    int unsigned        idle_pct = 0;
    int unsigned        mismatches = 0;
    int unsigned        labels_sent = 0;
    int unsigned        colors_checked = 0;
    int unsigned        settings_used = 0;

    index_to_hue_rgb_color dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_label_number (i_label_number),
        .o_done         (o_done),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_color hue_color(input logic [LABEL_BITS_DEF-1:0] label,
                                         input logic [STEPS_W-1:0] steps_reg);
        int unsigned steps;
        int unsigned quot;
        int unsigned resid;
        int unsigned num;
        int unsigned den;
        int unsigned rem;
        int unsigned up;
        int unsigned down;
        t_color      c;
        steps = (steps_reg == '0) ? 1 : int'(steps_reg);
        quot  = label / steps;
        resid = label % steps;
        num   = 6 * (8 * resid + OFFSET_EIGHTHS[quot % 7]);
        den   = 8 * steps;
        rem   = num % den;
        up    = (255 * rem) / den;
        down  = 255 - up;
        c.label = label;
        case (t_sector'(num / den))
            SEC_RED_GREEN_UP: begin
                c.red = LEVEL_MAX; c.green = COLOR_W'(up); c.blue = LEVEL_MIN;
            end
            SEC_GREEN_RED_DOWN: begin
                c.red = COLOR_W'(down); c.green = LEVEL_MAX; c.blue = LEVEL_MIN;
            end
            SEC_GREEN_BLUE_UP: begin
                c.red = LEVEL_MIN; c.green = LEVEL_MAX; c.blue = COLOR_W'(up);
            end
            SEC_BLUE_GREEN_DN: begin
                c.red = LEVEL_MIN; c.green = COLOR_W'(down); c.blue = LEVEL_MAX;
            end
            SEC_BLUE_RED_UP: begin
                c.red = COLOR_W'(up); c.green = LEVEL_MIN; c.blue = LEVEL_MAX;
            end
            default: begin
                c.red = LEVEL_MAX; c.green = LEVEL_MIN; c.blue = COLOR_W'(down);
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_channel(input string name, input t_color want,
                                 input logic [COLOR_W-1:0] got,
                                 input logic [COLOR_W-1:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("label %0d, %s is %0d, expected %0d",
                                      want.label, name, got, exp_val));
        end
    endtask

    task automatic plan(input t_req_kind kind, input int unsigned value);
        t_plan_entry e;
        e.kind  = kind;
        e.value = value;
        request_plan.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_color want;
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        running   = i_rst_n;
        if (i_rst_n) begin
            if (o_done) begin
                if (colors_due.size() == 0) begin
                    report_mismatch($sformatf("color (%0d,%0d,%0d) with no request outstanding",
                                              o_red, o_green, o_blue));
                end else begin
                    want = colors_due.pop_front();
                    check_channel("red", want, o_red, want.red);
                    check_channel("green", want, o_green, want.green);
                    check_channel("blue", want, o_blue, want.blue);
                    colors_checked++;
                end
            end
            if (start && !busy) begin
                colors_due.push_back(hue_color(i_label_number, steps_now));
                req_taken = 1'b1;
                labels_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                steps_now = i_cfg_data;
                cfg_taken = 1'b1;
                settings_used++;
            end
        end
    end

    always @(negedge i_clk) begin
        logic                      nxt_start;
        logic [LABEL_BITS_DEF-1:0] nxt_label;
        logic                      nxt_cfg_valid;
        logic [STEPS_W-1:0]        nxt_cfg_data;
        t_plan_entry               head;
        nxt_start     = start && !req_taken;
        nxt_label     = i_label_number;
        nxt_cfg_valid = i_cfg_valid && !cfg_taken;
        nxt_cfg_data  = i_cfg_data;
        if (running && !nxt_start && !nxt_cfg_valid && request_plan.size() != 0) begin
            head = request_plan[0];
            case (head.kind)
                REQ_LABEL: begin
                    if ($urandom_range(99) >= idle_pct) begin
                        request_plan.delete(0);
                        nxt_start = 1'b1;
                        nxt_label = LABEL_BITS_DEF'(head.value);
                    end
                end
                REQ_SET_STEPS: begin
                    if (colors_due.size() == 0) begin
                        request_plan.delete(0);
                        nxt_cfg_valid = 1'b1;
                        nxt_cfg_data  = STEPS_W'(head.value);
                    end
                end
                REQ_DRAIN: begin
                    if (colors_due.size() == 0) begin
                        request_plan.delete(0);
                    end
                end
                default: begin
                    request_plan.delete(0);
                    idle_pct = head.value;
                end
            endcase
        end
        start          <= nxt_start;
        i_label_number <= nxt_label;
        i_cfg_valid    <= nxt_cfg_valid;
        i_cfg_data     <= nxt_cfg_data;
    end

    initial begin
        int unsigned steps_list [8];
        int unsigned label;
        steps_list = '{255, 1, 128, 0, 3, 127, 254, 0};
        steps_list[3] = $urandom_range(0, 255);
        steps_list[7] = $urandom_range(1, 255);

        // With the reset step count of 8, these reach every sector and every offset.
        for (int l = 0; l < 8; l++) begin
            plan(REQ_LABEL, l);
        end
        for (int q = 1; q < 8; q++) begin
            plan(REQ_LABEL, 8 * q);
        end
        plan(REQ_LABEL, 16'hFFFF);
        plan(REQ_DRAIN, 0);
        // A step count of zero must behave as one.
        plan(REQ_SET_STEPS, 0);
        for (int l = 0; l < 7; l++) begin
            plan(REQ_LABEL, l);
        end
        plan(REQ_LABEL, 16'hFFFF);

        for (int p = 0; p < 8; p++) begin
            plan(REQ_IDLE_RATE, (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 48 : 12));
            plan(REQ_SET_STEPS, steps_list[p]);
            for (int n = 0; n < 80; n++) begin
                case ($urandom_range(3))
                    2: label = $urandom_range(0, 1023);
                    3: label = 16'hFFFF - $urandom_range(0, 1023);
                    default: label = $urandom_range(0, 16'hFFFF);
                endcase
                if ($urandom_range(39) == 0) begin
                    plan(REQ_DRAIN, 0);
                end
                plan(REQ_LABEL, label);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_plan.size() != 0 || start || i_cfg_valid || colors_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("covered %0d labels under %0d step count writes plus the reset value",
                 labels_sent, settings_used);
        $display("checked %0d colors, %0d mismatches", colors_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("timeout with %0d colors still outstanding", colors_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ihrc_pkg.sv
hdl/ihrc_div_cell.sv
hdl/ihrc_chain.sv
hdl/index_to_hue_rgb_color.sv
sim/index_to_hue_rgb_color_test.sv
